FILE: hw/rtl/hbfs_pkg.sv
// Shared types, constants and encoders for the hierarchical bitmap find-set unit.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package hbfs_pkg;

  localparam int WORD_BITS  = 64;
  localparam int LEAF_COUNT = 64;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_W     = $clog2(LEAF_COUNT);
  localparam int POS_W      = WORD_W + BIT_W;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [WORD_W-1:0]    word_idx_t;
  typedef logic [BIT_W-1:0]     bit_idx_t;
  typedef logic [POS_W-1:0]     pos_t;
  typedef logic [1:0]           op_t;

  // Operation codes
  localparam op_t OP_SET   = 2'd0;
  localparam op_t OP_CLEAR = 2'd1;
  localparam op_t OP_NEXT  = 2'd2;
  localparam op_t OP_PREV  = 2'd3;

  // Index of the lowest set bit; 63 when the word is zero
  function automatic bit_idx_t lowest_one(input word_t v);
    bit_idx_t n;
    n = bit_idx_t'(WORD_BITS - 1);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) n = bit_idx_t'(i);
    end
    return n;
  endfunction

  // Index of the highest set bit; 0 when the word is zero
  function automatic bit_idx_t highest_one(input word_t v);
    bit_idx_t n;
    n = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) n = bit_idx_t'(i);
    end
    return n;
  endfunction

endpackage

FILE: hw/rtl/hbfs_leaf_ram.sv
// Leaf word store: one write port and one read port with registered read data.
// Depends on hbfs_pkg for the word and index types.
`timescale 1ns / 1ps

module hbfs_leaf_ram (
  input  logic               clk,
  input  logic               rd_en,
  input  hbfs_pkg::word_idx_t rd_addr,
  output hbfs_pkg::word_t    rd_data,
  input  logic               wr_en,
  input  hbfs_pkg::word_idx_t wr_addr,
  input  hbfs_pkg::word_t    wr_data
);
  import hbfs_pkg::*;

  word_t mem [LEAF_COUNT];
  word_t rd_data_r;

  // Write back modified leaf words
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Registered read: data shows in the cycle after rd_en and holds otherwise
  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/hierarchical_bitmap_find_set_unit.sv
// Top level of the hierarchical bitmap find-set unit: sequencer, summary register
// and result register around the leaf RAM. Depends on hbfs_pkg and hbfs_leaf_ram.
//
//   channel  ports                                                    transfer
//   input    start, busy, in_op, in_position                          start && !busy
//   result   out_valid, out_found, out_found_position, out_nonempty   out_valid, 1 cycle
//
// Set, clear, and a search that hits in the start word or finds nothing in the
// summary pass through the leaf read state only; a search that moves on to another
// word also passes through the scan state for a second leaf RAM read. busy is
// high while an item is at work; a new item may be accepted in the cycle its
// predecessor's result shows. Reset clears the summary register, which also marks
// every leaf as empty, so no clearing pass is needed. The receiver cannot stall
// the result channel.
`timescale 1ns / 1ps

module hierarchical_bitmap_find_set_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hbfs_pkg::op_t       in_op,
  input  hbfs_pkg::pos_t      in_position,
  output logic                out_valid,
  output logic                out_found,
  output hbfs_pkg::pos_t      out_found_position,
  output logic                out_nonempty
);
  import hbfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LEAF = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0] state_r, state_nxt;
  op_t        op_r;
  word_idx_t  word_r;
  bit_idx_t   bit_r;
  word_idx_t  scan_word_r, scan_word_nxt;
  word_t      summary_r, summary_nxt;

  logic       res_valid_r, res_valid_nxt;
  logic       res_found_r, res_found_nxt;
  pos_t       res_pos_r, res_pos_nxt;
  logic       res_nonempty_r, res_nonempty_nxt;

  logic       accept;
  logic       rd_en;
  word_idx_t  rd_addr;
  word_t      rd_data;
  logic       wr_en;
  word_t      wr_data;

  word_t      leaf;
  word_t      leaf_mask;
  word_t      leaf_hit;
  word_t      sum_mask;
  word_t      sum_hit;
  word_idx_t  sum_idx;
  logic [WORD_W:0] word_up;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // A leaf whose summary bit is clear is empty, whatever the RAM holds
  assign leaf = rd_data & {WORD_BITS{summary_r[word_r]}};

  // Masks for the start word and for the summary scan
  assign word_up   = {1'b0, word_r} + 1'b1;
  assign leaf_mask = (op_r == OP_NEXT) ? ({WORD_BITS{1'b1}} << bit_r)
                                       : ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - bit_r));
  assign leaf_hit  = leaf & leaf_mask;
  assign sum_mask  = (op_r == OP_NEXT)
                   ? ({WORD_BITS{1'b1}} << word_up)
                   : ({WORD_BITS{1'b1}} >> ((WORD_W+1)'(WORD_BITS) - {1'b0, word_r}));
  assign sum_hit   = summary_r & sum_mask;
  assign sum_idx   = (op_r == OP_NEXT) ? word_idx_t'(lowest_one(sum_hit))
                                       : word_idx_t'(highest_one(sum_hit));

  // Sequence one item: read start leaf, modify or search, maybe read a second leaf
  always_comb begin
    state_nxt        = state_r;
    scan_word_nxt    = scan_word_r;
    summary_nxt      = summary_r;
    res_valid_nxt    = 1'b0;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    res_nonempty_nxt = res_nonempty_r;
    rd_en            = 1'b0;
    rd_addr          = in_position[POS_W-1:BIT_W];
    wr_en            = 1'b0;
    wr_data          = leaf;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          rd_en     = 1'b1;
          state_nxt = ST_LEAF;
        end
      end
      ST_LEAF: begin
        res_found_nxt = 1'b0;
        res_pos_nxt   = '0;
        case (op_r)
          OP_SET: begin
            wr_en                = 1'b1;
            wr_data              = leaf | (word_t'(1) << bit_r);
            summary_nxt[word_r]  = 1'b1;
            res_valid_nxt        = 1'b1;
            state_nxt            = ST_IDLE;
          end
          OP_CLEAR: begin
            wr_en                = 1'b1;
            wr_data              = leaf & ~(word_t'(1) << bit_r);
            summary_nxt[word_r]  = (wr_data != '0);
            res_valid_nxt        = 1'b1;
            state_nxt            = ST_IDLE;
          end
          default: begin
            if (leaf_hit != '0) begin
              res_found_nxt = 1'b1;
              res_pos_nxt   = {word_r, (op_r == OP_NEXT) ? lowest_one(leaf_hit)
                                                         : highest_one(leaf_hit)};
              res_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else if (sum_hit == '0) begin
              res_valid_nxt = 1'b1;
              state_nxt     = ST_IDLE;
            end else begin
              rd_en         = 1'b1;
              rd_addr       = sum_idx;
              scan_word_nxt = sum_idx;
              state_nxt     = ST_SCAN;
            end
          end
        endcase
        res_nonempty_nxt = (summary_nxt != '0);
      end
      ST_SCAN: begin
        // Summary bit is set, so the leaf holds at least one marked position
        res_found_nxt    = 1'b1;
        res_pos_nxt      = {scan_word_r, (op_r == OP_NEXT) ? lowest_one(rd_data)
                                                           : highest_one(rd_data)};
        res_nonempty_nxt = (summary_r != '0);
        res_valid_nxt    = 1'b1;
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and summary
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      summary_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      summary_r   <= summary_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // Hold the item and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      word_r <= in_position[POS_W-1:BIT_W];
      bit_r  <= in_position[BIT_W-1:0];
    end
    scan_word_r    <= scan_word_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    res_nonempty_r <= res_nonempty_nxt;
  end

  hbfs_leaf_ram u_leaf_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (word_r),
    .wr_data (wr_data)
  );

  assign out_valid          = res_valid_r;
  assign out_found          = res_found_r;
  assign out_found_position = res_pos_r;
  assign out_nonempty       = res_nonempty_r;

`ifndef SYNTHESIS
  // A result only shows once the sequencer is back at rest
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == ST_IDLE))
    else $error("result strobe while item still at work");

  // Find-next never returns a position below its start
  a_next_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found && (op_r == OP_NEXT)) |-> (out_found_position >= {word_r, bit_r}))
    else $error("find-next returned a lower position");

  // Find-prev never returns a position above its start
  a_prev_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found && (op_r == OP_PREV)) |-> (out_found_position <= {word_r, bit_r}))
    else $error("find-prev returned a higher position");

  // A miss reports position zero, and set or clear never reports a hit
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (!out_found || op_r == OP_SET || op_r == OP_CLEAR))
      |-> (!out_found && out_found_position == '0))
    else $error("miss or update reported a position");
`endif

endmodule

FILE: verif/bitmap_answer_checker.sv
// Checker for the hierarchical bitmap find-set unit: predicts every answer from its
// own copy of the leaf words and summary word, and compares the strobed results.
// Depends on hbfs_pkg for the port types and operation codes.
`timescale 1ns / 1ps

module bitmap_answer_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  hbfs_pkg::op_t  in_op,
  input  hbfs_pkg::pos_t in_position,
  input  logic           out_valid,
  input  logic           out_found,
  input  hbfs_pkg::pos_t out_found_position,
  input  logic           out_nonempty,
  output int             mismatches,
  output int             outstanding,
  output int             answers_seen,
  output int             search_hits
);

  import hbfs_pkg::*;

  localparam int POSITIONS   = 4096;
  localparam int REPORT_CAP  = 20;

  typedef struct packed {
    logic found;
    pos_t found_position;
    logic nonempty;
  } answer_t;

  word_t   leaf_marks [LEAF_COUNT];
  word_t   word_summary;
  answer_t pending_answers [$];
  answer_t due;
  int      err_n;
  int      seen_n;
  int      hit_n;

  // Scan helpers: -1 when the word holds no mark
  function automatic int lowest_mark(word_t v);
    int idx;
    idx = -1;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  function automatic int highest_mark(word_t v);
    int idx;
    idx = -1;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (v[i]) idx = i;
    end
    return idx;
  endfunction

  // Lowest mark at or above the start; nothing when starting past the end
  function automatic answer_t search_upward(pos_t from);
    answer_t a;
    word_t   m;
    int      w;
    int      b;
    int      hw;
    a = '0;
    if (int'(from) >= POSITIONS) return a;
    w = int'(from[POS_W-1:BIT_W]);
    b = int'(from[BIT_W-1:0]);
    m = leaf_marks[w] & (~word_t'(0) << b);
    if (m != '0) begin
      a.found = 1'b1;
      a.found_position = pos_t'(w * WORD_BITS + lowest_mark(m));
      return a;
    end
    if (w == LEAF_COUNT - 1) return a;
    // move on through the summary to the next nonzero word
    m = word_summary & (~word_t'(0) << (w + 1));
    if (m == '0) return a;
    hw = lowest_mark(m);
    a.found = 1'b1;
    a.found_position = pos_t'(hw * WORD_BITS + lowest_mark(leaf_marks[hw]));
    return a;
  endfunction

  // Highest mark at or below the start; a start past the end is pulled back
  function automatic answer_t search_downward(pos_t from);
    answer_t a;
    word_t   m;
    int      p;
    int      w;
    int      b;
    int      hw;
    a = '0;
    p = (int'(from) >= POSITIONS) ? POSITIONS - 1 : int'(from);
    w = p / WORD_BITS;
    b = p % WORD_BITS;
    m = leaf_marks[w] & (~word_t'(0) >> (WORD_BITS - 1 - b));
    if (m != '0) begin
      a.found = 1'b1;
      a.found_position = pos_t'(w * WORD_BITS + highest_mark(m));
      return a;
    end
    if (w == 0) return a;
    m = word_summary & (~word_t'(0) >> (WORD_BITS - w));
    if (m == '0) return a;
    hw = highest_mark(m);
    a.found = 1'b1;
    a.found_position = pos_t'(hw * WORD_BITS + highest_mark(leaf_marks[hw]));
    return a;
  endfunction

  // Apply one item to the shadow bitmap and return the answer it should give
  function automatic answer_t predict_bitmap_op(op_t op, pos_t pos);
    answer_t a;
    int      w;
    int      b;
    a = '0;
    w = int'(pos[POS_W-1:BIT_W]);
    b = int'(pos[BIT_W-1:0]);
    case (op)
      OP_SET: begin
        if (int'(pos) < POSITIONS) begin
          leaf_marks[w][b] = 1'b1;
          word_summary[w]  = 1'b1;
        end
      end
      OP_CLEAR: begin
        if (int'(pos) < POSITIONS) begin
          leaf_marks[w][b] = 1'b0;
          if (leaf_marks[w] == '0) word_summary[w] = 1'b0;
        end
      end
      OP_NEXT: a = search_upward(pos);
      default: a = search_downward(pos);
    endcase
    a.nonempty = (word_summary != '0);
    return a;
  endfunction

  // Predict on each accepted transfer, compare on each result strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (leaf_marks[i]) leaf_marks[i] = '0;
      word_summary = '0;
      pending_answers.delete();
      err_n  = 0;
      seen_n = 0;
      hit_n  = 0;
    end else begin
      if (start && busy === 1'b0) begin
        pending_answers.push_back(predict_bitmap_op(in_op, in_position));
      end
      if (out_valid === 1'b1) begin
        if (pending_answers.size() == 0) begin
          if (err_n < REPORT_CAP)
            $error("result with no item outstanding: found_position %0d",
                   out_found_position);
          err_n++;
        end else begin
          due = pending_answers.pop_front();
          seen_n++;
          if (due.found) hit_n++;
          if (out_found !== due.found) begin
            if (err_n < REPORT_CAP)
              $error("found: expected %0d, got %0d", due.found, out_found);
            err_n++;
          end
          if (out_found_position !== due.found_position) begin
            if (err_n < REPORT_CAP)
              $error("found_position: expected %0d, got %0d",
                     due.found_position, out_found_position);
            err_n++;
          end
          if (out_nonempty !== due.nonempty) begin
            if (err_n < REPORT_CAP)
              $error("nonempty: expected %0d, got %0d", due.nonempty, out_nonempty);
            err_n++;
          end
        end
      end
    end
    // publish counts so the top reads settled values at the edge
    mismatches   <= err_n;
    outstanding  <= pending_answers.size();
    answers_seen <= seen_n;
    search_hits  <= hit_n;
  end

endmodule

FILE: verif/testbench.sv
// Top of the find-set unit testbench: clock, reset, directed and random stimulus
// with random idle gaps, and the final verdict. Depends on hbfs_pkg, the unit and
// bitmap_answer_checker.
`timescale 1ns / 1ps

module testbench;

  import hbfs_pkg::*;

  localparam int TOTAL_ITEMS = 1450;
  localparam int OPENING_N   = 23;

  typedef enum int { MODE_FILL, MODE_DRAIN, MODE_MIXED } phase_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic start;
  logic busy;
  op_t  in_op;
  pos_t in_position;
  logic out_valid;
  logic out_found;
  pos_t out_found_position;
  logic out_nonempty;

  int        mismatches;
  int        outstanding;
  int        answers_seen;
  int        search_hits;
  int        op_tally [4] = '{default: 0};
  pos_t      marked_spots [$];
  word_idx_t focus_words [4];

  // Opening items: empty searches, word-edge marks, cross-word searches, emptying
  op_t  opening_ops [OPENING_N] = '{
    OP_NEXT, OP_PREV, OP_SET, OP_SET, OP_SET, OP_SET, OP_NEXT, OP_NEXT,
    OP_NEXT, OP_PREV, OP_PREV, OP_PREV, OP_CLEAR, OP_CLEAR, OP_PREV, OP_SET,
    OP_NEXT, OP_PREV, OP_CLEAR, OP_CLEAR, OP_CLEAR, OP_CLEAR, OP_NEXT};
  pos_t opening_pos [OPENING_N] = '{
    12'd0, 12'd4095, 12'd0, 12'd4095, 12'd63, 12'd64, 12'd0, 12'd1,
    12'd65, 12'd4095, 12'd4094, 12'd62, 12'd63, 12'd0, 12'd63, 12'd2000,
    12'd65, 12'd1999, 12'd64, 12'd4095, 12'd2000, 12'd5, 12'd4095};

  always #6 clk = ~clk;

  hierarchical_bitmap_find_set_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_nonempty       (out_nonempty)
  );

  bitmap_answer_checker answer_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_found          (out_found),
    .out_found_position (out_found_position),
    .out_nonempty       (out_nonempty),
    .mismatches         (mismatches),
    .outstanding        (outstanding),
    .answers_seen       (answers_seen),
    .search_hits        (search_hits)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Positions cluster in the focus words so searches meet marks often
  function automatic pos_t pick_position();
    int        r;
    word_idx_t w;
    r = $urandom_range(99);
    w = focus_words[$urandom_range(3)];
    if (r < 65) return {w, bit_idx_t'($urandom)};
    if (r < 75) return {w, ($urandom_range(1) ? ~bit_idx_t'(0) : bit_idx_t'(0))};
    if (r < 85) return $urandom_range(1) ? ~pos_t'(0) : pos_t'(0);
    return pos_t'($urandom);
  endfunction

  // Hold one item until transferred, then idle for the given gap
  task automatic issue_item(input op_t op, input pos_t pos, input int gap);
    start       <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    op_tally[op]++;
    if (gap > 0) begin
      // drop start and scramble the idle fields; the unit must ignore them
      start       <= 1'b0;
      in_op       <= op_t'($urandom);
      in_position <= pos_t'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : run_limit
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int          sent;
    int          episode_len;
    int          r;
    int          pick;
    int          drain_wait;
    bit          steady_flow;
    bit          drain_stuck;
    phase_mode_t mode;
    op_t         op;
    pos_t        pos;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_op       = OP_SET;
    in_position = '0;
    sent        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening
    for (int i = 0; i < OPENING_N; i++) begin
      issue_item(opening_ops[i], opening_pos[i], pick_gap());
      sent++;
    end

    // Random episodes: fill, drain or mixed over a few focus words
    while (sent < TOTAL_ITEMS) begin
      episode_len = $urandom_range(15, 80);
      mode        = phase_mode_t'($urandom_range(2));
      steady_flow = ($urandom_range(3) == 0);
      foreach (focus_words[i]) begin
        if ($urandom_range(4) == 0)
          focus_words[i] = $urandom_range(1) ? ~word_idx_t'(0) : word_idx_t'(0);
        else
          focus_words[i] = word_idx_t'($urandom);
      end
      repeat (episode_len) begin
        if (sent < TOTAL_ITEMS) begin
          r = $urandom_range(99);
          case (mode)
            MODE_FILL:  op = (r < 50) ? OP_SET : (r < 60) ? OP_CLEAR :
                             (r < 80) ? OP_NEXT : OP_PREV;
            MODE_DRAIN: op = (r < 15) ? OP_SET : (r < 65) ? OP_CLEAR :
                             (r < 83) ? OP_NEXT : OP_PREV;
            default:    op = op_t'(r % 4);
          endcase
          if (op == OP_CLEAR && marked_spots.size() > 0 && $urandom_range(9) < 8) begin
            pick = $urandom_range(marked_spots.size() - 1);
            pos  = marked_spots[pick];
            marked_spots.delete(pick);
          end else begin
            pos = pick_position();
            if (op == OP_SET) marked_spots.push_back(pos);
          end
          // the last item always drops start afterwards
          issue_item(op, pos, (sent == TOTAL_ITEMS - 1) ? 1 :
                              (steady_flow ? 0 : pick_gap()));
          sent++;
        end
      end
    end

    // Wait for the last answers, with a bound on the wait, then idle to catch anything stray
    drain_wait = 0;
    do begin
      @(posedge clk);
      drain_wait++;
    end while (outstanding != 0 && drain_wait < 200);
    drain_stuck = (outstanding != 0);
    if (drain_stuck) $error("%0d results never arrived", outstanding);
    repeat (8) @(posedge clk);

    $display("Sent %0d transfers: set %0d, clear %0d, find-next %0d, find-prev %0d.",
             sent, op_tally[OP_SET], op_tally[OP_CLEAR], op_tally[OP_NEXT],
             op_tally[OP_PREV]);
    $display("Checked %0d results, %0d of them searches that hit; %0d mismatches.",
             answers_seen, search_hits, mismatches);
    if (mismatches == 0 && !drain_stuck) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
